// ===== rtl/rcz_pkg.sv =====
// rcz_pkg: shared types and constants for the 5x5 RGB convolution core.
// Used by rcz_linebuf, rcz_filter and rgb_conv5x5_zero_pad_core; no dependencies.
`default_nettype none

package rcz_pkg;

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;

   localparam int CHANNELS   = 3;
   localparam int CH_W       = 8;
   localparam int PIX_W      = CHANNELS * CH_W;
   localparam int KSIZE      = 5;
   localparam int HALF       = KSIZE / 2;

   localparam int COEF_W     = 12;
   localparam int COEF_FRAC  = 8;
   localparam int COEF_ROW_W = KSIZE * COEF_W;

   localparam int PROD_W     = CH_W + 1 + COEF_W;
   localparam int RSUM_W     = PROD_W + $clog2(KSIZE);
   localparam int TSUM_W     = RSUM_W + $clog2(KSIZE);

   localparam int DIM_W                 = 11;
   localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;

   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_LSB    = 3;

   typedef enum logic {
      FUNC_PIXEL = 1'b0,
      FUNC_FLUSH = 1'b1
   } rcz_func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_ROW_0   = 3'd0,
      CSR_COEF_ROW_1   = 3'd1,
      CSR_COEF_ROW_2   = 3'd2,
      CSR_COEF_ROW_3   = 3'd3,
      CSR_COEF_ROW_4   = 3'd4,
      CSR_IMAGE_WIDTH  = 3'd5,
      CSR_IMAGE_HEIGHT = 3'd6
   } rcz_csr_type;

   typedef struct packed {
      rcz_func_type      func;
      logic [CH_W-1:0]   red_in;
      logic [CH_W-1:0]   green_in;
      logic [CH_W-1:0]   blue_in;
   } rcz_req_type;

   typedef struct packed {
      logic [CH_W-1:0]   red_out;
      logic [CH_W-1:0]   green_out;
      logic [CH_W-1:0]   blue_out;
      logic              last_pixel;
   } rcz_rsp_type;

   // Per-step tap validity, index 0 = newest row / newest column of the window
   typedef struct packed {
      logic              emit;
      logic              last;
      logic [KSIZE-1:0]  row_ok;
      logic [KSIZE-1:0]  col_ok;
   } rcz_tap_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/rcz_linebuf.sv =====
// rcz_linebuf: four chained line stores giving one 5-pixel column per stream step.
// Depends on rcz_pkg.
`default_nettype none

module rcz_linebuf import rcz_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          load_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]  load_col,
   input  logic [PIX_W-1:0]              load_pix,
   input  logic                          shift_en,
   output logic [PIX_W-1:0]              stack [KSIZE]
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int LINES = KSIZE - 1;

   logic [COL_W-1:0] col_ff;
   logic [PIX_W-1:0] pix_ff;
   logic [PIX_W-1:0] byp_ff [LINES];
   logic             byp_v_ff;

   // same column written by the leaving step as read by the arriving one
   always_ff @(posedge clock) begin
      if (load_en) begin
         col_ff   <= load_col;
         pix_ff   <= load_pix;
         byp_v_ff <= shift_en && (col_ff == load_col);
         for (int i = 0; i < LINES; i++) begin
            byp_ff[i] <= stack[i];
         end
      end
   end

   assign stack[0] = pix_ff;

   for (genvar i = 0; i < LINES; i++) begin : g_line
      logic [PIX_W-1:0] mem [MAX_WIDTH];
      logic [PIX_W-1:0] rd_ff;

      always_ff @(posedge clock) begin
         if (shift_en) begin
            mem[col_ff] <= stack[i];
         end
         if (load_en) begin
            rd_ff <= mem[load_col];
         end
      end

      assign stack[i+1] = byp_v_ff ? byp_ff[i] : rd_ff;
   end

endmodule

`default_nettype wire

// ===== rtl/rcz_filter.sv =====
// rcz_filter: 5x5 window, masked multiply, registered adder tree and saturation.
// Depends on rcz_pkg.
`default_nettype none

module rcz_filter import rcz_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   shift_en,
   input  logic [PIX_W-1:0]       stack [KSIZE],
   input  rcz_tap_ctl_type        tap_ctl,
   input  logic [COEF_ROW_W-1:0]  coef [KSIZE],
   output logic                   shift_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rcz_rsp_type            rsp_payload
);

   logic [PIX_W-1:0]          win_ff [KSIZE][KSIZE];
   rcz_tap_ctl_type           s2_ctl_ff;
   logic                      s2_v_ff;

   logic signed [PROD_W-1:0]  prod_in [CHANNELS][KSIZE][KSIZE];
   logic signed [PROD_W-1:0]  prod_ff [CHANNELS][KSIZE][KSIZE];
   logic                      s3_v_ff;
   logic                      s3_last_ff;

   logic signed [RSUM_W-1:0]  rsum_in [CHANNELS][KSIZE];
   logic signed [RSUM_W-1:0]  rsum_ff [CHANNELS][KSIZE];
   logic                      s4_v_ff;
   logic                      s4_last_ff;

   logic signed [TSUM_W-1:0]  tot_in [CHANNELS];
   logic signed [TSUM_W-1:0]  tot_ff [CHANNELS];
   logic                      s5_v_ff;
   logic                      s5_last_ff;

   rcz_rsp_type               rsp_ff;
   logic                      out_v_ff;

   logic rdy3, rdy4, rdy5, rdy_out;

   function automatic logic [CH_W-1:0] sat_pix(input logic signed [TSUM_W-1:0] v);
      logic [TSUM_W-COEF_FRAC-1:0] q;
      q = v[TSUM_W-1:COEF_FRAC];
      if (v[TSUM_W-1] || (v == '0)) begin
         return '0;
      end else if (|q[TSUM_W-COEF_FRAC-1:CH_W]) begin
         return '1;
      end
      return q[CH_W-1:0];
   endfunction

   assign rdy_out     = !out_v_ff || rsp_ready;
   assign rdy5        = !s5_v_ff || rdy_out;
   assign rdy4        = !s4_v_ff || rdy5;
   assign rdy3        = !s3_v_ff || rdy4;
   assign shift_ready = !s2_v_ff || rdy3;

   // masked pixel times coefficient; window row k, column j hits kernel (4-k, 4-j)
   always_comb begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
         for (int k = 0; k < KSIZE; k++) begin
            for (int j = 0; j < KSIZE; j++) begin
               prod_in[ch][k][j] =
                  $signed({1'b0, win_ff[k][j][CH_W*ch +: CH_W]
                                 & {CH_W{s2_ctl_ff.row_ok[k] & s2_ctl_ff.col_ok[j]}}})
                  * $signed(coef[KSIZE-1-k][COEF_W*(KSIZE-1-j) +: COEF_W]);
            end
         end
      end
   end

   always_comb begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
         for (int k = 0; k < KSIZE; k++) begin
            rsum_in[ch][k] = '0;
            for (int j = 0; j < KSIZE; j++) begin
               rsum_in[ch][k] = rsum_in[ch][k] + RSUM_W'(prod_ff[ch][k][j]);
            end
         end
      end
   end

   always_comb begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
         tot_in[ch] = '0;
         for (int k = 0; k < KSIZE; k++) begin
            tot_in[ch] = tot_in[ch] + TSUM_W'(rsum_ff[ch][k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         s5_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (shift_en) begin
            s2_v_ff <= tap_ctl.emit;
         end else if (rdy3) begin
            s2_v_ff <= 1'b0;
         end
         if (rdy3) begin
            s3_v_ff <= s2_v_ff;
         end
         if (rdy4) begin
            s4_v_ff <= s3_v_ff;
         end
         if (rdy5) begin
            s5_v_ff <= s4_v_ff;
         end
         if (rdy_out) begin
            out_v_ff <= s5_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         s2_ctl_ff <= tap_ctl;
         for (int k = 0; k < KSIZE; k++) begin
            win_ff[k][0] <= stack[k];
            for (int j = 1; j < KSIZE; j++) begin
               win_ff[k][j] <= win_ff[k][j-1];
            end
         end
      end
      if (rdy3) begin
         prod_ff    <= prod_in;
         s3_last_ff <= s2_ctl_ff.last;
      end
      if (rdy4) begin
         rsum_ff    <= rsum_in;
         s4_last_ff <= s3_last_ff;
      end
      if (rdy5) begin
         tot_ff     <= tot_in;
         s5_last_ff <= s4_last_ff;
      end
      if (rdy_out && s5_v_ff) begin
         rsp_ff.red_out    <= sat_pix(tot_ff[0]);
         rsp_ff.green_out  <= sat_pix(tot_ff[1]);
         rsp_ff.blue_out   <= sat_pix(tot_ff[2]);
         rsp_ff.last_pixel <= s5_last_ff;
      end
   end

   assign rsp_valid   = out_v_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/rgb_conv5x5_zero_pad_core.sv =====
// rgb_conv5x5_zero_pad_core: top level of the 5x5 RGB convolution with zero padding.
// Depends on rcz_pkg, rcz_linebuf and rcz_filter.
//
// Takes one pixel or flush transfer per clock unless stalled or realigning, and
// returns one filtered pixel per transfer once 2*W+2 pixels of the frame have gone
// in; the result passes the step, window, product, row-sum, total and output
// registers, and a stalled output holds the input back once they are full. Pixels
// run through four line stores of MAX_WIDTH x 24 bits (one read and one write each
// per clock) and a 5x5 window; 75 multipliers feed a two-level registered adder
// tree. Flush transfers push out the last 2*W+2 results, the final one flagged
// with last_pixel. When the whole frame holds fewer than 2*W+2 pixels, the core
// takes padding steps after the last pixel to realign its window before it takes
// the first flush. Pixels after frame end and flushes before it are taken and
// dropped. Writing image_width or image_height restarts the frame.
`default_nettype none

module rgb_conv5x5_zero_pad_core import rcz_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  rcz_req_type            req_payload,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rcz_rsp_type            rsp_payload,

   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   localparam int W_W    = $clog2(MAX_WIDTH + 1);
   localparam int H_W    = $clog2(MAX_HEIGHT + 1);
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int LEAD_W = $clog2(2 * MAX_WIDTH + 3);

   logic [COEF_ROW_W-1:0] coef_ff [KSIZE];
   logic [DIM_W-1:0]      width_ff;
   logic [DIM_W-1:0]      height_ff;

   rcz_csr_type           csr_idx;
   logic                  csr_wr;
   logic                  dim_wr;

   logic [W_W-1:0]        w_eff;
   logic [H_W-1:0]        h_eff;
   logic [LEAD_W-1:0]     lead;

   logic [COL_W-1:0]      scol_ff;
   logic [H_W-1:0]        in_row_ff;
   logic [LEAD_W-1:0]     sp_ff;
   logic [COL_W-1:0]      ocol_ff;
   logic [ROW_W-1:0]      orow_ff;

   logic                  frame_in;
   logic                  lead_hit;
   logic                  pad;
   logic                  rdy1;
   logic                  shift_ready;
   logic                  shift_en;
   logic                  req_xfer;
   logic                  pix_acc;
   logic                  fl_acc;
   logic                  step;
   logic                  step_emit;
   logic                  step_last;
   logic                  scol_wrap;
   logic                  ocol_wrap;
   logic [PIX_W-1:0]      step_pix;
   logic [W_W:0]          colx;
   logic [W_W:0]          wx;
   logic [H_W:0]          rowx;
   logic [H_W:0]          hx;

   rcz_tap_ctl_type       s1_ctl_in;
   rcz_tap_ctl_type       s1_ctl_ff;
   logic                  s1_v_ff;

   logic [PIX_W-1:0]      stack [KSIZE];

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_idx    = rcz_csr_type'(csr_paddr[CSR_ADDR_W-1:CSR_LSB]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign dim_wr     = csr_wr && (csr_idx == CSR_IMAGE_WIDTH || csr_idx == CSR_IMAGE_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < KSIZE; k++) begin
            coef_ff[k] <= '0;
         end
         width_ff  <= DIM_RESET;
         height_ff <= DIM_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx) inside
            CSR_COEF_ROW_0, CSR_COEF_ROW_1, CSR_COEF_ROW_2,
            CSR_COEF_ROW_3, CSR_COEF_ROW_4: coef_ff[csr_idx] <= csr_pwdata[COEF_ROW_W-1:0];
            CSR_IMAGE_WIDTH:                width_ff  <= csr_pwdata[DIM_W-1:0];
            CSR_IMAGE_HEIGHT:               height_ff <= csr_pwdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx) inside
         CSR_COEF_ROW_0, CSR_COEF_ROW_1, CSR_COEF_ROW_2,
         CSR_COEF_ROW_3, CSR_COEF_ROW_4: csr_prdata = CSR_DATA_W'(coef_ff[csr_idx]);
         CSR_IMAGE_WIDTH:                csr_prdata = CSR_DATA_W'(width_ff);
         CSR_IMAGE_HEIGHT:               csr_prdata = CSR_DATA_W'(height_ff);
         default:                        csr_prdata = '0;
      endcase
   end

   // frame size clamped to the supported range
   always_comb begin
      if (width_ff == '0) begin
         w_eff = W_W'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = W_W'(MAX_WIDTH);
      end else begin
         w_eff = W_W'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = H_W'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h_eff = H_W'(MAX_HEIGHT);
      end else begin
         h_eff = H_W'(height_ff);
      end
   end

   assign lead = LEAD_W'({w_eff, 1'b0}) + LEAD_W'(2);

   // step control: a step moves the raster stream on by one position
   assign frame_in  = in_row_ff >= h_eff;
   assign lead_hit  = sp_ff == lead;
   assign pad       = frame_in && !lead_hit;
   assign rdy1      = !s1_v_ff || shift_ready;
   assign shift_en  = s1_v_ff && shift_ready;
   assign req_ready = rdy1 && !pad;
   assign req_xfer  = req_valid && req_ready;
   assign pix_acc   = req_xfer && req_payload.func == FUNC_PIXEL && !frame_in;
   assign fl_acc    = req_xfer && req_payload.func == FUNC_FLUSH && frame_in;
   assign step      = pix_acc || fl_acc || (pad && rdy1);
   assign step_emit = (pix_acc && lead_hit) || fl_acc;
   assign scol_wrap = W_W'(scol_ff) == w_eff - W_W'(1);
   assign ocol_wrap = W_W'(ocol_ff) == w_eff - W_W'(1);
   assign step_last = step_emit && ocol_wrap && (H_W'(orow_ff) == h_eff - H_W'(1));
   assign step_pix  = pix_acc ? {req_payload.blue_in, req_payload.green_in,
                                 req_payload.red_in} : '0;

   // taps outside the frame are zero
   assign colx = (W_W+1)'(ocol_ff);
   assign wx   = (W_W+1)'(w_eff);
   assign rowx = (H_W+1)'(orow_ff);
   assign hx   = (H_W+1)'(h_eff);

   always_comb begin
      s1_ctl_in.emit = step_emit;
      s1_ctl_in.last = step_last;
      for (int k = 0; k < KSIZE; k++) begin
         if (k <= HALF) begin
            s1_ctl_in.row_ok[k] = rowx + (H_W+1)'(HALF - k) < hx;
            s1_ctl_in.col_ok[k] = colx + (W_W+1)'(HALF - k) < wx;
         end else begin
            s1_ctl_in.row_ok[k] = rowx >= (H_W+1)'(k - HALF);
            s1_ctl_in.col_ok[k] = colx >= (W_W+1)'(k - HALF);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scol_ff   <= '0;
         in_row_ff <= '0;
         sp_ff     <= '0;
         ocol_ff   <= '0;
         orow_ff   <= '0;
         s1_v_ff   <= 1'b0;
      end else begin
         if (dim_wr || (step && step_last)) begin
            scol_ff   <= '0;
            in_row_ff <= '0;
            sp_ff     <= '0;
            ocol_ff   <= '0;
            orow_ff   <= '0;
         end else if (step) begin
            scol_ff <= scol_wrap ? '0 : scol_ff + COL_W'(1);
            if (pix_acc && scol_wrap) begin
               in_row_ff <= in_row_ff + H_W'(1);
            end
            if (!lead_hit) begin
               sp_ff <= sp_ff + LEAD_W'(1);
            end
            if (step_emit) begin
               ocol_ff <= ocol_wrap ? '0 : ocol_ff + COL_W'(1);
               if (ocol_wrap) begin
                  orow_ff <= orow_ff + ROW_W'(1);
               end
            end
         end
         if (rdy1) begin
            s1_v_ff <= step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         s1_ctl_ff <= s1_ctl_in;
      end
   end

   rcz_linebuf #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_linebuf (
      .clock    (clock),
      .load_en  (step),
      .load_col (scol_ff),
      .load_pix (step_pix),
      .shift_en (shift_en),
      .stack    (stack)
   );

   rcz_filter u_filter (
      .clock       (clock),
      .reset       (reset),
      .shift_en    (shift_en),
      .stack       (stack),
      .tap_ctl     (s1_ctl_ff),
      .coef        (coef_ff),
      .shift_ready (shift_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   assert property (@(posedge clock) disable iff (reset)
      step_emit |-> lead_hit)
      else $error("result produced before the window was filled");

   assert property (@(posedge clock) disable iff (reset)
      (step && step_last && !dim_wr) |=>
         (sp_ff == '0 && in_row_ff == '0 && scol_ff == '0 && ocol_ff == '0))
      else $error("counters not cleared after last pixel");

   assert property (@(posedge clock) disable iff (reset)
      (W_W'(scol_ff) < w_eff) && (in_row_ff <= h_eff))
      else $error("stream position outside the frame");

endmodule

`default_nettype wire

// ===== sim/tb_rgb_conv5x5_zero_pad_core.sv =====
// Self-checking testbench for rgb_conv5x5_zero_pad_core: directed and random frames,
// predicted per transfer by a scoreboard class and checked result by result.
// Depends on rcz_pkg and the core RTL only.
module tb_rgb_conv5x5_zero_pad_core;
   timeunit 1ns;
   timeprecision 1ps;

   import rcz_pkg::*;

   localparam int RESET_CYCLES  = 7;
   localparam int IDLE_PCT      = 34;
   localparam int SETTLE_CYCLES = 64;
   localparam int HOLD_CYCLES   = 200;
   localparam int STALL_LIMIT   = 4000;
   localparam int RANDOM_ITEMS  = 280;
   localparam int RING_DEPTH    = 4 * MAX_WIDTH_DEF + 8;
   localparam int DIM_MAX_REG   = 2 ** DIM_W - 1;

   typedef enum int {
      KERN_IDENTITY,
      KERN_BOX,
      KERN_SHARPEN,
      KERN_NARROW,
      KERN_RANDOM,
      KERN_MAX_POS,
      KERN_MAX_NEG,
      KERN_EXTREMES
   } kernel_kind_type;

   class conv5x5_scoreboard;
      logic [COEF_ROW_W-1:0] kernel_rows [KSIZE];
      logic [DIM_W-1:0]      width_reg;
      logic [DIM_W-1:0]      height_reg;
      logic [PIX_W-1:0]      pix_ring [RING_DEPTH];
      int                    in_col, in_row, out_col, out_row;
      rcz_rsp_type           pending_pixels [$];
      int                    mismatches, results_checked;

      function new();
         foreach (kernel_rows[i]) kernel_rows[i] = '0;
         width_reg  = DIM_RESET;
         height_reg = DIM_RESET;
         mismatches = 0;
         results_checked = 0;
         restart();
      endfunction

      function void restart();
         in_col  = 0;
         in_row  = 0;
         out_col = 0;
         out_row = 0;
      endfunction

      function int eff_dim(logic [DIM_W-1:0] v, int lim);
         if (v < 1) return 1;
         if (v > lim) return lim;
         return int'(v);
      endfunction

      function void write_reg(rcz_csr_type idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_IMAGE_WIDTH: begin
               width_reg = val[DIM_W-1:0];
               restart();
            end
            CSR_IMAGE_HEIGHT: begin
               height_reg = val[DIM_W-1:0];
               restart();
            end
            default: kernel_rows[int'(idx)] = val[COEF_ROW_W-1:0];
         endcase
      endfunction

      // next output pixel of the frame; advances the output position
      function rcz_rsp_type filtered_pixel(int w, int h);
         int acc [CHANNELS];
         int dy, dx, yy, xx, ch, sum;
         logic signed [COEF_W-1:0] cf;
         logic [PIX_W-1:0] pix;
         logic [CH_W-1:0] chan [CHANNELS];
         rcz_rsp_type o;
         foreach (acc[i]) acc[i] = 0;
         for (dy = 0; dy < KSIZE; dy++) begin
            yy = out_row + dy - HALF;
            if (yy >= 0 && yy < h) begin
               for (dx = 0; dx < KSIZE; dx++) begin
                  xx = out_col + dx - HALF;
                  if (xx >= 0 && xx < w) begin
                     pix = pix_ring[(yy * w + xx) % RING_DEPTH];
                     cf  = kernel_rows[dy][dx*COEF_W +: COEF_W];
                     for (ch = 0; ch < CHANNELS; ch++)
                        acc[ch] += int'(pix[ch*CH_W +: CH_W]) * int'(cf);
                  end
               end
            end
         end
         for (ch = 0; ch < CHANNELS; ch++) begin
            sum = acc[ch] >>> COEF_FRAC;
            if (acc[ch] <= 0) chan[ch] = '0;
            else if (sum > 255) chan[ch] = 8'hFF;
            else chan[ch] = sum[CH_W-1:0];
         end
         o.red_out   = chan[0];
         o.green_out = chan[1];
         o.blue_out  = chan[2];
         out_col++;
         if (out_col >= w) begin
            out_col = 0;
            out_row++;
         end
         o.last_pixel = (out_row >= h);
         if (o.last_pixel) restart();
         return o;
      endfunction

      // returns 1 when the transfer is taken into the frame, 0 when dropped
      function bit note_input(rcz_req_type it);
         int w, h, total, q;
         w = eff_dim(width_reg, MAX_WIDTH_DEF);
         h = eff_dim(height_reg, MAX_HEIGHT_DEF);
         total = w * h;
         q = in_row * w + in_col;
         if (it.func == FUNC_PIXEL) begin
            if (q >= total) return 0;
            pix_ring[q % RING_DEPTH] = {it.blue_in, it.green_in, it.red_in};
            in_col++;
            if (in_col >= w) begin
               in_col = 0;
               in_row++;
            end
            if (q >= 2 * w + 2) pending_pixels.push_back(filtered_pixel(w, h));
            return 1;
         end
         if (q < total) return 0;
         pending_pixels.push_back(filtered_pixel(w, h));
         return 1;
      endfunction

      function void check_result(rcz_rsp_type got);
         rcz_rsp_type want;
         if (pending_pixels.size() == 0) begin
            $error("unexpected result %h", got);
            mismatches++;
            return;
         end
         want = pending_pixels.pop_front();
         results_checked++;
         if (got.red_out !== want.red_out) begin
            $error("red_out: expected %0d, got %0d", want.red_out, got.red_out);
            mismatches++;
         end
         if (got.green_out !== want.green_out) begin
            $error("green_out: expected %0d, got %0d", want.green_out, got.green_out);
            mismatches++;
         end
         if (got.blue_out !== want.blue_out) begin
            $error("blue_out: expected %0d, got %0d", want.blue_out, got.blue_out);
            mismatches++;
         end
         if (got.last_pixel !== want.last_pixel) begin
            $error("last_pixel: expected %0d, got %0d", want.last_pixel, got.last_pixel);
            mismatches++;
         end
      endfunction

      function int outstanding();
         return pending_pixels.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   rcz_req_type           req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rcz_rsp_type           rsp_payload;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   conv5x5_scoreboard sb = new();

   int tx_idle_pct = IDLE_PCT;
   int rx_idle_pct = IDLE_PCT;
   bit hold_request = 1'b0;
   int hold_left = 0;
   int stall_cycles = 0;
   int items_in = 0;
   int items_used = 0;
   int frames = 0;

   rgb_conv5x5_zero_pad_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // result side: check each transfer, then pick next ready (random, or a long hold-off)
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) sb.check_result(rsp_payload);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
   end

   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("rgb_conv5x5_zero_pad_core regression: fail");
      $finish;
   end

   task automatic write_csr(rcz_csr_type idx, logic [CSR_DATA_W-1:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(idx) << CSR_LSB;
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.write_reg(idx, val);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_kernel(kernel_kind_type kind);
      logic [COEF_ROW_W-1:0] row;
      logic [COEF_W-1:0] c;
      int r, k;
      bit centre, on_cross;
      for (r = 0; r < KSIZE; r++) begin
         for (k = 0; k < KSIZE; k++) begin
            centre   = (r == HALF && k == HALF);
            on_cross = (r == HALF && (k == HALF - 1 || k == HALF + 1))
                    || (k == HALF && (r == HALF - 1 || r == HALF + 1));
            case (kind)
               KERN_IDENTITY: c = centre ? 12'h100 : 12'h000;
               KERN_BOX:      c = 12'h00A;
               KERN_SHARPEN:  c = centre ? 12'h500 : (on_cross ? 12'hF00 : 12'h000);
               KERN_NARROW:   c = COEF_W'($urandom_range(128) - 64);
               KERN_RANDOM:   c = COEF_W'($urandom);
               KERN_MAX_POS:  c = 12'h7FF;
               KERN_MAX_NEG:  c = 12'h800;
               default: begin
                  case (r)
                     0:       c = 12'h800;
                     1:       c = 12'h7FF;
                     2:       c = centre ? 12'h100 : 12'h000;
                     3:       c = 12'hFFF;
                     default: c = 12'h000;
                  endcase
               end
            endcase
            row[k*COEF_W +: COEF_W] = c;
         end
         write_csr(rcz_csr_type'(r), CSR_DATA_W'(row));
      end
   endtask

   // effective size to register value, sometimes via the clamped out-of-range values
   function automatic logic [CSR_DATA_W-1:0] dim_reg_value(int d, int lim);
      if (d == 1 && $urandom_range(1)) return '0;
      if (d == lim && $urandom_range(1))
         return CSR_DATA_W'($urandom_range(DIM_MAX_REG, lim + 1));
      return CSR_DATA_W'(d);
   endfunction

   task automatic set_frame(int w, int h);
      write_csr(CSR_IMAGE_WIDTH, dim_reg_value(w, MAX_WIDTH_DEF));
      write_csr(CSR_IMAGE_HEIGHT, dim_reg_value(h, MAX_HEIGHT_DEF));
   endtask

   function automatic logic [PIX_W-1:0] rand_rgb();
      logic [PIX_W-1:0] v;
      int ch;
      v = PIX_W'($urandom);
      for (ch = 0; ch < CHANNELS; ch++)
         if ($urandom_range(9) < 2) v[ch*CH_W +: CH_W] = $urandom_range(1) ? 8'hFF : 8'h00;
      return v;
   endfunction

   task automatic send_item(rcz_func_type f, logic [PIX_W-1:0] rgb);
      rcz_req_type it;
      it.func     = f;
      it.red_in   = rgb[7:0];
      it.green_in = rgb[15:8];
      it.blue_in  = rgb[23:16];
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= it;
      do @(posedge clock); while (!req_ready);
      items_in++;
      if (sb.note_input(it)) items_used++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   task automatic settle_idle();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // n_pix below w*h leaves the frame unfinished (no closing flush transfers)
   task automatic play_frame(int w, int h, int n_pix, bit noisy);
      int total;
      total = w * h;
      for (int i = 0; i < n_pix; i++) begin
         if (noisy && $urandom_range(99) < 4) send_item(FUNC_FLUSH, rand_rgb());
         if (noisy && $urandom_range(99) < 2) drain_results();
         send_item(FUNC_PIXEL, rand_rgb());
      end
      if (n_pix < total) return;
      if (noisy && $urandom_range(3) == 0)
         repeat ($urandom_range(2, 1)) send_item(FUNC_PIXEL, rand_rgb());
      repeat ((total < 2 * w + 2) ? total : 2 * w + 2) send_item(FUNC_FLUSH, rand_rgb());
      frames++;
   endtask

   task automatic random_phase();
      int w, h, n_pix;
      if ($urandom_range(9) == 0) begin
         w = $urandom_range(40, 13);
         h = $urandom_range(4, 1);
      end else begin
         w = $urandom_range(12, 1);
         h = $urandom_range(8, 1);
      end
      if ($urandom_range(1)) load_kernel(kernel_kind_type'($urandom_range(KERN_EXTREMES)));
      set_frame(w, h);
      do begin
         n_pix = ($urandom_range(9) == 0) ? $urandom_range(w * h - 1, 0) : w * h;
         play_frame(w, h, n_pix, 1'b1);
      end while (n_pix == w * h && $urandom_range(2) == 0);
      settle_idle();
   endtask

   initial begin
      int used_start;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // 2x2 frame: flush too early, extreme pixels, pixel past frame end, flushes
      load_kernel(KERN_EXTREMES);
      set_frame(2, 2);
      send_item(FUNC_FLUSH, 24'hFFFFFF);
      send_item(FUNC_PIXEL, 24'hFFFFFF);
      send_item(FUNC_PIXEL, 24'h000000);
      send_item(FUNC_PIXEL, 24'hFF00FF);
      send_item(FUNC_PIXEL, 24'h00FF00);
      send_item(FUNC_PIXEL, 24'h123456);
      repeat (4) send_item(FUNC_FLUSH, 24'h000000);
      settle_idle();

      // zero sizes clamp to 1x1; two frames back to back
      load_kernel(KERN_IDENTITY);
      write_csr(CSR_IMAGE_WIDTH, '0);
      write_csr(CSR_IMAGE_HEIGHT, '0);
      repeat (2) begin
         send_item(FUNC_PIXEL, 24'hFF5AA5);
         send_item(FUNC_FLUSH, 24'hFFFFFF);
      end
      settle_idle();

      // unfinished frame, restarted by the next size write
      load_kernel(KERN_SHARPEN);
      set_frame(3, 4);
      repeat (9) send_item(FUNC_PIXEL, rand_rgb());
      settle_idle();

      // widest frame, unfinished: too few pixels for any result
      load_kernel(KERN_RANDOM);
      set_frame(MAX_WIDTH_DEF, 1);
      play_frame(MAX_WIDTH_DEF, 1, 64, 1'b0);
      settle_idle();

      // tallest frame, partial: no idling, receiver held off so the core backs up
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      load_kernel(KERN_BOX);
      set_frame(1, MAX_HEIGHT_DEF);
      hold_request = 1'b1;
      play_frame(1, MAX_HEIGHT_DEF, 120, 1'b0);
      settle_idle();
      tx_idle_pct = IDLE_PCT;
      rx_idle_pct = IDLE_PCT;

      used_start = items_used;
      while (items_used - used_start < RANDOM_ITEMS) random_phase();
      settle_idle();

      $display("%0d complete frames, %0d transfers in (%0d taken), %0d results checked",
               frames, items_in, items_used, sb.results_checked);
      $display("sizes 1x1 to 1024 wide/tall, kernels from identity to full-scale coefficients");
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("rgb_conv5x5_zero_pad_core regression: pass");
      end else begin
         $display("rgb_conv5x5_zero_pad_core regression: fail");
      end
      $finish;
   end

endmodule
